// ===== sv/lcg_permutation_generator_macros.svh =====
// lcg_permutation_generator_macros.svh
// Assertion macros shared by the permutation generator RTL; no other dependencies.
// Define NO_ASSERTIONS to compile every check away.
`ifndef LCG_PERMUTATION_GENERATOR_MACROS_SVH
`define LCG_PERMUTATION_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset
`define LPG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must hold in the cycle after a trigger
`define LPG_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LPG_ASSERT(lbl, clk, rst, prop, msg)
`define LPG_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== sv/lpg_pkg.sv =====
// lpg_pkg.sv
// Types, codes and constants shared by the permutation generator controller and datapath.
// No dependencies.
`default_nettype none

package lpg_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CTR_W     = 5;
  // Restoring remainder: one dividend bit per step
  localparam int MOD_STEPS = 32;
  // Index quotient: one bit per step, value below 2^CNT_W
  localparam int QUO_STEPS = CNT_W;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_RESEED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PERM   = 2'd2;
  // Spare code: accepted and dropped
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MODULUS = 2'd2;

  // Configuration reset values
  localparam logic [DATA_W-1:0] MULTIPLIER_RESET   = 32'd69069;
  localparam logic [DATA_W-1:0] INCREMENT_RESET    = 32'd1;
  localparam logic [DATA_W-1:0] HALF_MODULUS_RESET = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RES0,
    ST_MUL,
    ST_ADD,
    ST_CHK,
    ST_MOD,
    ST_MODFIN,
    ST_RES1,
    ST_FILL,
    ST_PMUL,
    ST_PDIV,
    ST_SWAPRD,
    ST_SWAPJ,
    ST_SWAPK,
    ST_EMITRD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {IDX_HOLD, IDX_CLEAR, IDX_INC, IDX_DEC} idx_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_FILL, WR_J, WR_K} mem_wr_t;
  typedef enum logic [1:0] {RD_NONE, RD_SWAP, RD_EMIT} mem_rd_t;
  typedef enum logic {RES_SEED, RES_PERM} res_sel_t;

  typedef struct packed {
    logic     load_req;
    idx_op_t  idx_op;
    logic     mul_seed;
    logic     add_inc;
    logic     mod_start;
    logic     mod_step;
    logic     mod_fin;
    logic     pmul;
    logic     pdiv_step;
    mem_rd_t  mem_rd;
    mem_wr_t  mem_wr;
    logic     res_load;
    res_sel_t res_sel;
    logic     seed_from_value;
  } lpg_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind_r;
    logic              in_count_zero;
    logic              idx_zero;
    logic              idx_last;
    logic              cnt_zero;
    logic              seed_ge_tm;
    logic              res_free;
  } lpg_status_t;

endpackage

`default_nettype wire

// ===== sv/lpg_ctrl.sv =====
// lpg_ctrl.sv
// Sequencer for reseed, draw and shuffle requests; drives the datapath by command struct.
// Depends on lpg_pkg and lcg_permutation_generator_macros.svh.
`default_nettype none
`include "lcg_permutation_generator_macros.svh"

module lpg_ctrl
  import lpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [KIND_W-1:0] kind,
  output logic              req_stall,
  input  lpg_status_t       status,
  output lpg_cmd_t          cmd
);

  state_t state;
  state_t state_next;
  state_t after_draw;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take a new request only when idle
  assign req_stall = (state != ST_IDLE);

  // A draw feeds either a single result or one shuffle step
  assign after_draw = (status.kind_r == KIND_DRAW) ? ST_RES1 : ST_PMUL;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          cmd.idx_op   = IDX_CLEAR;
          case (kind)
            KIND_RESEED: state_next = ST_RES0;
            KIND_DRAW:   state_next = ST_MUL;
            KIND_PERM: begin
              if (!status.in_count_zero) begin
                state_next = ST_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RES0: begin
        if (status.res_free) begin
          cmd.res_load        = 1'b1;
          cmd.res_sel         = RES_SEED;
          cmd.seed_from_value = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul_seed = 1'b1;
        state_next   = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_inc = 1'b1;
        state_next  = ST_CHK;
      end
      ST_CHK: begin
        if (status.seed_ge_tm) begin
          cmd.mod_start = 1'b1;
          state_next    = ST_MOD;
        end else begin
          state_next = after_draw;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.cnt_zero) begin
          state_next = ST_MODFIN;
        end
      end
      ST_MODFIN: begin
        cmd.mod_fin = 1'b1;
        state_next  = after_draw;
      end
      ST_RES1: begin
        if (status.res_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_SEED;
          state_next   = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd.mem_wr = WR_FILL;
        if (status.idx_last) begin
          state_next = ST_MUL;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      ST_PMUL: begin
        cmd.pmul   = 1'b1;
        state_next = ST_PDIV;
      end
      ST_PDIV: begin
        cmd.pdiv_step = 1'b1;
        if (status.cnt_zero) begin
          state_next = ST_SWAPRD;
        end
      end
      ST_SWAPRD: begin
        cmd.mem_rd = RD_SWAP;
        state_next = ST_SWAPJ;
      end
      ST_SWAPJ: begin
        cmd.mem_wr = WR_J;
        state_next = ST_SWAPK;
      end
      ST_SWAPK: begin
        cmd.mem_wr = WR_K;
        if (status.idx_zero) begin
          cmd.idx_op = IDX_CLEAR;
          state_next = ST_EMITRD;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_next = ST_MUL;
        end
      end
      ST_EMITRD: begin
        cmd.mem_rd = RD_EMIT;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.res_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PERM;
          if (status.idx_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_op = IDX_INC;
            state_next = ST_EMITRD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `LPG_ASSERT_NEXT(a_perm_start, clk, rst, req_valid && !req_stall && kind == KIND_PERM && !status.in_count_zero, state == ST_FILL, "shuffle request did not start the fill")
  `LPG_ASSERT_NEXT(a_shuffle_done, clk, rst, state == ST_SWAPK && status.idx_zero, state == ST_EMITRD && cmd.mem_rd == RD_EMIT, "last swap not followed by emission")

endmodule

`default_nettype wire

// ===== sv/lpg_dpath.sv =====
// lpg_dpath.sv
// Datapath: configuration, seed, LCG step, remainder and index dividers, store, result register.
// Depends on lpg_pkg and lcg_permutation_generator_macros.svh.
`default_nettype none
`include "lcg_permutation_generator_macros.svh"

module lpg_dpath
  import lpg_pkg::*;
#(
  parameter int MAX_COUNT = 64
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  lpg_cmd_t             cmd,
  output lpg_status_t          status,
  input  logic [KIND_W-1:0]    kind,
  input  logic [DATA_W-1:0]    value,
  input  logic [CNT_W-1:0]     count,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [DATA_W-1:0]    data,
  output logic                 last
);

  localparam int AW    = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int NUM_W = DATA_W + CNT_W;
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_COUNT);

  logic [DATA_W-1:0] multiplier;
  logic [DATA_W-1:0] increment;
  logic [DATA_W-1:0] half_modulus;
  logic [DATA_W:0]   two_m;

  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  n_sat;

  logic [DATA_W-1:0] seed;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] step_sum;
  logic [DATA_W-1:0] seed_step;

  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_plus;
  logic [CTR_W-1:0]  cnt;

  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              rem_ge;

  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  dsh;
  logic              num_ge;
  logic [CNT_W-1:0]  quo;
  logic [CNT_W-1:0]  j_clamp;

  logic [AW-1:0]     perm_mem [MAX_COUNT];
  logic [AW-1:0]     j;
  logic [AW-1:0]     rd_a;
  logic [AW-1:0]     rd_b;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     wr_data;
  logic              wr_en;
  logic              res_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier   <= MULTIPLIER_RESET;
      increment    <= INCREMENT_RESET;
      half_modulus <= HALF_MODULUS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MULTIPLIER:   multiplier   <= cfg_data;
        CFG_INCREMENT:    increment    <= cfg_data;
        CFG_HALF_MODULUS: half_modulus <= cfg_data;
        default: ;
      endcase
    end
  end

  // Modulus 2M, with a zero half modulus taken as one
  assign two_m = {(half_modulus == '0) ? DATA_W'(1) : half_modulus, 1'b0};

  // Latch the request; saturate the permutation length
  assign n_sat = (count > N_MAX) ? N_MAX : count;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r  <= kind;
      value_r <= value;
      n_r     <= n_sat;
    end
  end

  // LCG step: product registered, then add; a zero result steps once more, giving increment
  assign step_sum  = prod + increment;
  assign seed_step = (step_sum == '0) ? increment : step_sum;

  always_ff @(posedge clk) begin
    if (cmd.mul_seed) begin
      prod <= multiplier * seed;
    end
  end

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cmd.add_inc) begin
      seed <= seed_step;
    end else if (cmd.mod_fin) begin
      seed <= rem + 1'b1;
    end else if (cmd.res_load && cmd.seed_from_value) begin
      seed <= value_r;
    end
  end

  // Step counter shared by both dividers
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      cnt <= CTR_W'(MOD_STEPS - 1);
    end else if (cmd.pmul) begin
      cnt <= CTR_W'(QUO_STEPS - 1);
    end else if (cmd.mod_step || cmd.pdiv_step) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Restoring remainder of (seed - 1) by 2M, one bit a cycle
  assign rem_sh  = {rem, dvd[DATA_W-1]};
  assign rem_ge  = (rem_sh >= two_m);
  assign rem_sub = rem_sh - two_m;

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      dvd <= seed - 1'b1;
      rem <= '0;
    end else if (cmd.mod_step) begin
      dvd <= {dvd[DATA_W-2:0], 1'b0};
      rem <= rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end
  end

  // Index: seed*(k+1) / 2M, quotient below 2^CNT_W, one bit a cycle
  assign idx_plus = idx + 1'b1;
  assign num_ge   = (num >= dsh);

  always_ff @(posedge clk) begin
    if (cmd.pmul) begin
      num <= {{CNT_W{1'b0}}, seed} * {{DATA_W{1'b0}}, idx_plus};
      dsh <= {two_m, {(CNT_W-1){1'b0}}};
      quo <= '0;
    end else if (cmd.pdiv_step) begin
      if (num_ge) begin
        num <= num - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[CNT_W-2:0], num_ge};
    end
  end

  // Clamp the index to k
  assign j_clamp = (quo > idx) ? idx : quo;

  // Entry counter
  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      IDX_CLEAR: idx <= '0;
      IDX_INC:   idx <= idx + 1'b1;
      IDX_DEC:   idx <= idx - 1'b1;
      default:   ;
    endcase
  end

  // Permutation store: one write port, two registered read ports
  assign rd_addr_a = (cmd.mem_rd == RD_SWAP) ? j_clamp[AW-1:0] : idx[AW-1:0];

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx[AW-1:0];
    wr_data = idx[AW-1:0];
    case (cmd.mem_wr)
      WR_FILL: begin
        wr_addr = idx[AW-1:0];
        wr_data = idx[AW-1:0];
      end
      WR_J: begin
        wr_addr = j;
        wr_data = rd_b;
      end
      WR_K: begin
        wr_addr = idx[AW-1:0];
        wr_data = rd_a;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd == RD_SWAP || cmd.mem_rd == RD_EMIT) begin
      rd_a <= perm_mem[rd_addr_a];
    end
    if (cmd.mem_rd == RD_SWAP) begin
      rd_b <= perm_mem[idx[AW-1:0]];
      j    <= j_clamp[AW-1:0];
    end
  end

  // Result register: refill as soon as the held transfer completes
  assign res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (cmd.res_sel == RES_PERM) begin
        data <= DATA_W'(rd_a);
        last <= status.idx_last;
      end else begin
        data <= seed;
        last <= 1'b1;
      end
    end
  end

  // Status to the controller
  assign status.kind_r        = kind_r;
  assign status.in_count_zero = (count == '0);
  assign status.idx_zero      = (idx == '0);
  assign status.idx_last      = (idx == n_r - 1'b1);
  assign status.cnt_zero      = (cnt == '0);
  assign status.seed_ge_tm    = ({1'b0, seed} >= two_m);
  assign status.res_free      = res_free;

  `LPG_ASSERT(a_load_free, clk, rst, cmd.res_load |-> res_free, "result loaded over a pending transfer")
  `LPG_ASSERT_NEXT(a_reduce_range, clk, rst, cmd.mod_fin, seed != '0 && seed <= $past(two_m), "reduced seed outside one to 2M")
  `LPG_ASSERT_NEXT(a_perm_range, clk, rst, cmd.res_load && cmd.res_sel == RES_PERM, data < DATA_W'(n_r), "permutation element out of range")

endmodule

`default_nettype wire

// ===== sv/lcg_permutation_generator.sv =====
// A reseed result is loaded once the output register is free; a draw passes multiply, add and check,
// and the 32-step remainder unit (one bit per cycle) when the seed needs reducing.
// Permutation of n entries: n fill writes, then per entry a draw, the 7-step index divider and a
// swap written in turn on the store's single write port; then each element is read and loaded.
// One request at a time; the next is taken once the last result sits in the output register.
// Reset: registers to defaults, seed zero; the permutation store is not cleared.
`default_nettype none

module lcg_permutation_generator
  import lpg_pkg::*;
#(
  parameter int MAX_COUNT = 64
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [KIND_W-1:0]    kind,
  input  logic [DATA_W-1:0]    value,
  input  logic [CNT_W-1:0]     count,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [DATA_W-1:0]    data,
  output logic                 last,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  lpg_cmd_t    cmd;
  lpg_status_t status;

  // Sequencer
  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .kind      (kind),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, store and result register
  lpg_dpath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (kind),
    .value     (value),
    .count     (count),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .data      (data),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== verif/lpg_checker.sv =====
// lpg_checker.sv
// Predicts and checks every result transfer of the LCG permutation generator.
// Depends on lpg_pkg for widths, request kinds and register indexes.
`timescale 1ns / 1ps

module lpg_checker
  import lpg_pkg::*;
#(
  parameter int MAX_COUNT = 64
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  logic [KIND_W-1:0]    kind,
  input  logic [DATA_W-1:0]    value,
  input  logic [CNT_W-1:0]     count,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  logic [DATA_W-1:0]    data,
  input  logic                 last,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   words_due
);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } gen_word_t;

  // Shadow of the generator: registers, seed and permutation store
  logic [DATA_W-1:0] mult_r;
  logic [DATA_W-1:0] incr_r;
  logic [DATA_W-1:0] half_mod_r;
  logic [DATA_W-1:0] seed_r;
  logic [5:0]        perm_r [64];

  gen_word_t due_words [$];
  int        fail_tally = 0;

  assign mismatches = fail_tally;

  // One LCG step followed by the fold into 1..2M
  function automatic logic [DATA_W-1:0] lcg_next(input logic [DATA_W-1:0] cur);
    logic [63:0]       span;
    logic [63:0]       s;
    logic [63:0]       q;
    logic [DATA_W-1:0] nxt;
    span = (half_mod_r == '0) ? 64'd2 : {32'd0, half_mod_r} * 64'd2;
    nxt  = mult_r * cur + incr_r;
    if (nxt == '0)
      nxt = mult_r * nxt + incr_r;
    s = {32'd0, nxt};
    if (s > span - 64'd1) begin
      q = (s - 64'd1) / span;
      s = s - q * span;
    end
    return s[DATA_W-1:0];
  endfunction

  // Work out the results of one accepted request and queue them
  task automatic predict_request(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v,
                                 input logic [CNT_W-1:0] c);
    int          n;
    int          pos;
    logic [63:0] span;
    logic [63:0] pick;
    logic [5:0]  held;
    span = (half_mod_r == '0) ? 64'd2 : {32'd0, half_mod_r} * 64'd2;
    case (k)
      KIND_RESEED: begin
        due_words.push_back('{data: seed_r, last: 1'b1});
        seed_r = v;
      end
      KIND_DRAW: begin
        seed_r = lcg_next(seed_r);
        due_words.push_back('{data: seed_r, last: 1'b1});
      end
      KIND_PERM: begin
        n = (int'(c) > MAX_COUNT) ? MAX_COUNT : int'(c);
        for (pos = 0; pos < n; pos++)
          perm_r[pos] = 6'(pos);
        // Fisher-Yates from the top entry down, index clamped to the entry
        for (pos = n - 1; pos >= 0; pos--) begin
          seed_r = lcg_next(seed_r);
          pick   = ({32'd0, seed_r} * 64'(pos + 1)) / span;
          if (pick > 64'(pos))
            pick = 64'(pos);
          held               = perm_r[pick[5:0]];
          perm_r[pick[5:0]]  = perm_r[pos];
          perm_r[pos]        = held;
        end
        for (pos = 0; pos < n; pos++)
          due_words.push_back('{data: {26'd0, perm_r[pos]}, last: (pos == n - 1)});
      end
      default: ;
    endcase
  endtask

  // Report one failure
  task automatic report(input string what, input logic [DATA_W-1:0] want,
                        input logic [DATA_W-1:0] got);
    fail_tally++;
    $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    gen_word_t want;
    if (rst) begin
      mult_r     = MULTIPLIER_RESET;
      incr_r     = INCREMENT_RESET;
      half_mod_r = HALF_MODULUS_RESET;
      seed_r     = '0;
      due_words.delete();
    end else begin
      // Track register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_MULTIPLIER:   mult_r     = cfg_data;
          CFG_INCREMENT:    incr_r     = cfg_data;
          CFG_HALF_MODULUS: half_mod_r = cfg_data;
          default: ;
        endcase
      end
      // Compare each result transfer with the oldest queued word
      if (res_valid && !res_stall) begin
        if (due_words.size() == 0) begin
          report("unexpected result, data", 'x, data);
        end else begin
          want = due_words.pop_front();
          if (data !== want.data)
            report("data", want.data, data);
          if (last !== want.last)
            report("last", {31'd0, want.last}, {31'd0, last});
        end
      end
      // Predict each request transfer
      if (req_valid && !req_stall)
        predict_request(kind, value, count);
    end
    words_due = due_words.size();
  end

endmodule

// ===== verif/tb_lcg_permutation_generator.sv =====
// tb_lcg_permutation_generator.sv
// Top of the permutation generator testbench: clock, reset, stimulus and verdict.
// Depends on lpg_pkg, lcg_permutation_generator and lpg_checker.
`timescale 1ns / 1ps

module tb_lcg_permutation_generator;
  import lpg_pkg::*;

  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int SETTLE_CYCLE = 100;
  localparam int SEG_ITEMS    = 80;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [KIND_W-1:0]    kind;
  logic [DATA_W-1:0]    value;
  logic [CNT_W-1:0]     count;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [DATA_W-1:0]    data;
  logic                 last;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int mismatches;
  int words_due;
  int send_idle_pct = 36;
  int recv_idle_pct = 58;
  int cycle_count   = 0;

  always #1 clk = ~clk;

  lcg_permutation_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .value     (value),
    .count     (count),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .data      (data),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lpg_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .value      (value),
    .count      (count),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .data       (data),
    .last       (last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  // Stall the result channel at random
  always @(negedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit with %0d words outstanding", words_due);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request and hold it until the transfer; entered and left at a falling edge
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v,
                              input logic [CNT_W-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    value     <= v;
    count     <= c;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted word has arrived
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0)
      @(negedge clk);
  endtask

  // Present one register write for a cycle; the caller drops the enable afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Reprogram all registers once the block has gone quiet
  task automatic program_regs(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] inc,
                              input logic [DATA_W-1:0] half);
    wait_drained();
    repeat (SETTLE_CYCLE) @(negedge clk);
    write_reg(CFG_MULTIPLIER, m);
    write_reg(CFG_INCREMENT, inc);
    write_reg(CFG_HALF_MODULUS, half);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int                seg;
    int                taken;
    int                pick;
    logic [DATA_W-1:0] cfg_m;
    logic [DATA_W-1:0] cfg_i;
    logic [DATA_W-1:0] cfg_h;
    logic [CNT_W-1:0]  len;

    rst       = 1'b1;
    req_valid = 1'b0;
    kind      = KIND_RESEED;
    value     = '0;
    count     = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_MULTIPLIER;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under reset settings: extremes, zero and oversized counts, unused kind
    send_request(KIND_RESEED, 32'h0000_0000, 7'd1);
    send_request(KIND_DRAW, 32'h0, 7'd1);
    send_request(KIND_RESEED, 32'hFFFF_FFFF, 7'd1);
    send_request(KIND_DRAW, 32'h0, 7'd1);
    send_request(KIND_PERM, 32'h0, 7'd1);
    send_request(KIND_PERM, 32'h0, 7'd64);
    send_request(KIND_PERM, 32'h0, 7'd0);
    send_request(KIND_UNUSED, 32'hFFFF_FFFF, 7'd127);
    send_request(KIND_PERM, 32'h0, 7'd127);
    send_request(KIND_PERM, 32'h0, 7'd65);

    // Step to zero and repeat; seed folded to exactly 2M so the index needs clamping
    program_regs(32'd1, 32'd1, 32'd1);
    send_request(KIND_RESEED, 32'hFFFF_FFFF, 7'd0);
    send_request(KIND_DRAW, 32'h0, 7'd0);
    send_request(KIND_DRAW, 32'h0, 7'd0);
    send_request(KIND_PERM, 32'h0, 7'd4);

    // Zero half modulus, zero multiplier and increment: seed stuck at zero
    program_regs(32'd0, 32'd0, 32'd0);
    send_request(KIND_DRAW, 32'h0, 7'd0);
    send_request(KIND_PERM, 32'h0, 7'd3);
    send_request(KIND_RESEED, 32'd5, 7'd0);

    // Largest registers: no fold ever happens
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_DRAW, 32'h0, 7'd0);
    send_request(KIND_PERM, 32'h0, 7'd8);
    send_request(KIND_DRAW, 32'h0, 7'd0);

    // Random part: six settings, idling swapped after two and dropped after four
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin cfg_m = MULTIPLIER_RESET; cfg_i = INCREMENT_RESET;
                 cfg_h = HALF_MODULUS_RESET; end
        1: begin cfg_m = $urandom | 32'd1; cfg_i = $urandom;
                 cfg_h = $urandom_range(1, 1000); end
        2: begin cfg_m = 32'hFFFF_FFFF; cfg_i = 32'd0; cfg_h = 32'd1; end
        3: begin cfg_m = $urandom; cfg_i = $urandom; cfg_h = $urandom; end
        4: begin cfg_m = $urandom; cfg_i = 32'hFFFF_FFFF; cfg_h = 32'h7FFF_FFFF; end
        default: begin cfg_m = MULTIPLIER_RESET; cfg_i = INCREMENT_RESET;
                       cfg_h = 32'hFFFF_FFFF; end
      endcase
      if (seg == 2) begin
        send_idle_pct = 58;
        recv_idle_pct = 36;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_regs(cfg_m, cfg_i, cfg_h);

      taken = 0;
      while (taken < SEG_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Noise the block drops
          if (pick < 4)
            send_request(KIND_UNUSED, $urandom, 7'($urandom_range(0, 127)));
          else
            send_request(KIND_PERM, $urandom, 7'd0);
        end else begin
          if (pick < 28) begin
            case ($urandom_range(0, 9))
              0:       send_request(KIND_RESEED, 32'h0, 7'($urandom_range(0, 127)));
              1:       send_request(KIND_RESEED, 32'hFFFF_FFFF, 7'($urandom_range(0, 127)));
              default: send_request(KIND_RESEED, $urandom, 7'($urandom_range(0, 127)));
            endcase
          end else if (pick < 55) begin
            send_request(KIND_DRAW, $urandom, 7'($urandom_range(0, 127)));
          end else begin
            // Mostly short permutations, a few full or oversized
            case ($urandom_range(0, 19))
              0:       len = 7'($urandom_range(65, 127));
              1:       len = 7'd64;
              2, 3, 4: len = 7'($urandom_range(9, 63));
              default: len = 7'($urandom_range(1, 8));
            endcase
            send_request(KIND_PERM, $urandom, len);
          end
          taken++;
          // Hold the sender back until the block has emptied
          if (taken == SEG_ITEMS / 2)
            wait_drained();
        end
      end
    end

    // Let the last words and any late extras through
    wait_drained();
    repeat (SETTLE_CYCLE) @(negedge clk);
    if (mismatches == 0 && words_due == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lpg_pkg.sv
sv/lpg_ctrl.sv
sv/lpg_dpath.sv
sv/lcg_permutation_generator.sv
verif/lpg_checker.sv
verif/tb_lcg_permutation_generator.sv
